// File: src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition that holds on every rising clock edge, off during reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

// File: src/edh_pkg.sv
// Package with widths, pipeline depths and types of the distance pipeline.
package edh_pkg;

    localparam int CW          = 24;
    localparam int DW          = 25;
    localparam int SW          = 50;
    localparam int RW          = 25;
    localparam int ITERATIONS  = 10;
    localparam int FIRST_SHIFT = 13;
    localparam int ITER_DEPTH  = SW + 1;
    localparam int FRONT_DEPTH = 3;
    localparam int LATENCY     = FRONT_DEPTH + ITERATIONS * ITER_DEPTH + 1;
    localparam logic [RW-1:0] RES_MAX = {RW{1'b1}};

    typedef struct packed {
        logic v;
        logic z;
    } edh_ctl_t;

endpackage

// File: src/edh_heron_iter.sv
// One Heron step: bit-per-stage restoring divider S/E, then E = (E + S/E) >> 1.
`include "assert_macros.svh"

module edh_heron_iter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  edh_pkg::edh_ctl_t          ctl_in,
    input  logic [edh_pkg::SW-1:0]     s_in,
    input  logic [edh_pkg::SW-1:0]     e_in,
    output edh_pkg::edh_ctl_t          ctl_out,
    output logic [edh_pkg::SW-1:0]     s_out,
    output logic [edh_pkg::SW-1:0]     e_out
);

    localparam int SW = edh_pkg::SW;

    edh_pkg::edh_ctl_t ctl_reg [SW];
    logic [SW-1:0]     s_reg   [SW];
    logic [SW-1:0]     e_reg   [SW];
    logic [SW-1:0]     rem_reg [SW];
    logic [SW-1:0]     q_reg   [SW];

    edh_pkg::edh_ctl_t ctl_next [SW];
    logic [SW-1:0]     s_next   [SW];
    logic [SW-1:0]     e_next   [SW];
    logic [SW-1:0]     rem_next [SW];
    logic [SW-1:0]     q_next   [SW];

    edh_pkg::edh_ctl_t out_ctl_reg;
    logic [SW-1:0]     out_s_reg;
    logic [SW-1:0]     out_e_reg;
    logic [SW:0]       sum;

    genvar k;
    generate
        for (k = 0; k < SW; k++) begin : g_div
            edh_pkg::edh_ctl_t ctl_src;
            logic [SW-1:0]     s_src;
            logic [SW-1:0]     e_src;
            logic [SW-1:0]     rem_src;
            logic [SW-1:0]     q_src;
            logic [SW:0]       trial;
            logic              ge;

            if (k == 0) begin : g_first
                always_comb
                begin
                    ctl_src.v = ctl_in.v;
                    ctl_src.z = ctl_in.z | (e_in == '0);
                    s_src     = s_in;
                    e_src     = e_in;
                    rem_src   = '0;
                    q_src     = '0;
                end
            end else begin : g_rest
                always_comb
                begin
                    ctl_src = ctl_reg[k-1];
                    s_src   = s_reg[k-1];
                    e_src   = e_reg[k-1];
                    rem_src = rem_reg[k-1];
                    q_src   = q_reg[k-1];
                end
            end

            always_comb
            begin
                trial       = {rem_src, s_src[SW-1-k]};
                ge          = (trial >= {1'b0, e_src});
                ctl_next[k] = ctl_src;
                s_next[k]   = s_src;
                e_next[k]   = e_src;
                rem_next[k] = ge ? SW'(trial - {1'b0, e_src}) : trial[SW-1:0];
                q_next[k]   = {q_src[SW-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    ctl_reg[k] <= '0;
                end
                else
                begin
                    ctl_reg[k] <= ctl_next[k];
                end
            end

            always_ff @(posedge clk)
            begin
                s_reg[k]   <= s_next[k];
                e_reg[k]   <= e_next[k];
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    endgenerate

    assign sum = {1'b0, e_reg[SW-1]} + {1'b0, q_reg[SW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl_reg <= '0;
        end
        else
        begin
            out_ctl_reg <= ctl_reg[SW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_s_reg <= s_reg[SW-1];
        out_e_reg <= sum[SW:1];
    end

    assign ctl_out = out_ctl_reg;
    assign s_out   = out_s_reg;
    assign e_out   = out_e_reg;

    `ASSERT_IMPL(a_zero_carried, clk, rst_n, ctl_in.v && (ctl_in.z || e_in == '0),
        ##(edh_pkg::ITER_DEPTH) (ctl_out.v && ctl_out.z))
    `ASSERT_IMPL(a_valid_carried, clk, rst_n, ctl_in.v, ##(edh_pkg::ITER_DEPTH) ctl_out.v)
    `ASSERT_IMPL(a_remainder_small, clk, rst_n, ctl_reg[SW-1].v && !ctl_reg[SW-1].z,
        rem_reg[SW-1] < e_reg[SW-1])

endmodule

// File: src/euclidean_distance_3d_heron.sv
// Top level: 3D Euclidean distance of two Q12.12 points by Heron square root.
//
// Usage:
//   Drive ax, ay, az, bx, by, bz and raise start for one cycle per beat.
//   busy stays low: the pipeline takes a new beat on every clock cycle.
//   For a magnitude, tie bx, by, bz to zero.
//   done is high for exactly one cycle with dist_res (unsigned Q13.12);
//   the receiver must take the beat in that cycle and cannot stall it.
// Pipeline: a beat passes the front end, the Heron steps and the output
//   register before done. Front end: differences, squares, sum of squares.
//   Each Heron step is a 50-stage bit-per-stage divider plus one update
//   stage; ten steps are chained.
// Throughput: one beat per cycle, sustained.
// Reset: rst_n clears all valid bits; in-flight beats are dropped and no
//   done pulse follows until a new beat is accepted.
module euclidean_distance_3d_heron (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [edh_pkg::CW-1:0] ax,
    input  logic signed [edh_pkg::CW-1:0] ay,
    input  logic signed [edh_pkg::CW-1:0] az,
    input  logic signed [edh_pkg::CW-1:0] bx,
    input  logic signed [edh_pkg::CW-1:0] by,
    input  logic signed [edh_pkg::CW-1:0] bz,
    output logic                        done,
    output logic [edh_pkg::RW-1:0]      dist_res
);

    localparam int DW = edh_pkg::DW;
    localparam int SW = edh_pkg::SW;
    localparam int NI = edh_pkg::ITERATIONS;

    logic              v1_reg, v2_reg, v3_reg, done_reg;
    logic [DW-1:0]     mx_reg, my_reg, mz_reg;
    logic [2*DW-1:0]   qx_reg, qy_reg, qz_reg;
    logic [SW-1:0]     s_reg, e0_reg;
    logic [edh_pkg::RW-1:0] res_reg;

    logic signed [DW-1:0] dx, dy, dz;
    logic [2*DW+1:0]   s_next;
    logic [edh_pkg::RW-1:0] res_next;

    edh_pkg::edh_ctl_t ctl_c [NI+1];
    logic [SW-1:0]     s_c   [NI+1];
    logic [SW-1:0]     e_c   [NI+1];

    assign busy = 1'b0;

    assign dx = DW'(ax) - DW'(bx);
    assign dy = DW'(ay) - DW'(by);
    assign dz = DW'(az) - DW'(bz);
    assign s_next = {2'b00, qx_reg} + {2'b00, qy_reg} + {2'b00, qz_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= ctl_c[NI].v;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg <= dx[DW-1] ? DW'(-dx) : DW'(dx);
        my_reg <= dy[DW-1] ? DW'(-dy) : DW'(dy);
        mz_reg <= dz[DW-1] ? DW'(-dz) : DW'(dz);
        qx_reg <= mx_reg * mx_reg;
        qy_reg <= my_reg * my_reg;
        qz_reg <= mz_reg * mz_reg;
        s_reg  <= s_next[SW-1:0];
        e0_reg <= SW'(s_next[SW-1:0] >> edh_pkg::FIRST_SHIFT);
        res_reg <= res_next;
    end

    assign ctl_c[0] = '{v: v3_reg, z: 1'b0};
    assign s_c[0]   = s_reg;
    assign e_c[0]   = e0_reg;

    genvar i;
    generate
        for (i = 0; i < NI; i++) begin : g_iter
            edh_heron_iter u_iter (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl_in  (ctl_c[i]),
                .s_in    (s_c[i]),
                .e_in    (e_c[i]),
                .ctl_out (ctl_c[i+1]),
                .s_out   (s_c[i+1]),
                .e_out   (e_c[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        if (ctl_c[NI].z)
        begin
            res_next = '0;
        end
        else if (e_c[NI] > SW'(edh_pkg::RES_MAX))
        begin
            res_next = edh_pkg::RES_MAX;
        end
        else
        begin
            res_next = e_c[NI][edh_pkg::RW-1:0];
        end
    end

    assign done     = done_reg;
    assign dist_res = res_reg;

    `ASSERT_IMPL(a_latency, clk, rst_n, start, ##(edh_pkg::LATENCY) done)
    `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    `ASSERT_IMPL(a_zero_result, clk, rst_n, ctl_c[NI].v && ctl_c[NI].z, ##1 (dist_res == '0))

endmodule

// File: bench/edh_checker.sv
// Checker for the 3D distance pipeline: watches beats, predicts distances, compares.
`timescale 1ns / 100ps

module edh_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [edh_pkg::CW-1:0] ax,
    input  logic signed [edh_pkg::CW-1:0] ay,
    input  logic signed [edh_pkg::CW-1:0] az,
    input  logic signed [edh_pkg::CW-1:0] bx,
    input  logic signed [edh_pkg::CW-1:0] by,
    input  logic signed [edh_pkg::CW-1:0] bz,
    input  logic                          done,
    input  logic [edh_pkg::RW-1:0]        dist_res,
    output int                            errors
);

    logic [edh_pkg::RW-1:0] dist_expected[$];
    int err_count = 0;

    function automatic logic [63:0] sq_delta(logic signed [edh_pkg::CW-1:0] a,
                                             logic signed [edh_pkg::CW-1:0] b);
        logic signed [edh_pkg::DW-1:0] d;
        logic [edh_pkg::DW-1:0] m;
        d = edh_pkg::DW'(a) - edh_pkg::DW'(b);
        m = d[edh_pkg::DW-1] ? edh_pkg::DW'(-d) : edh_pkg::DW'(d);
        return 64'(m) * 64'(m);
    endfunction

    function automatic logic [edh_pkg::RW-1:0] heron_distance(logic [63:0] s);
        logic [63:0] e;
        e = s >> edh_pkg::FIRST_SHIFT;
        for (int i = 0; i < edh_pkg::ITERATIONS; i++)
        begin
            if (e == 0)
                return '0;
            e = (e + s / e) >> 1;
        end
        if (e > 64'(edh_pkg::RES_MAX))
            return edh_pkg::RES_MAX;
        return e[edh_pkg::RW-1:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        err_count++;
    endtask

    assign errors = err_count;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                dist_expected.push_back(heron_distance(sq_delta(ax, bx) + sq_delta(ay, by)
                                                       + sq_delta(az, bz)));
            if (done)
            begin
                if (dist_expected.size() == 0)
                    report_mismatch("result with nothing pending");
                else if (dist_res !== dist_expected[0])
                begin
                    report_mismatch($sformatf("dist_res %0d, want %0d", dist_res,
                                              dist_expected[0]));
                    void'(dist_expected.pop_front());
                end
                else
                    void'(dist_expected.pop_front());
            end
        end
    end

    function automatic int pending();
        return dist_expected.size();
    endfunction

endmodule

// File: bench/tb_euclidean_distance_3d_heron.sv
// Testbench top: drives point pairs into the distance pipeline and gives the verdict.
`timescale 1ns / 100ps

module tb_euclidean_distance_3d_heron;

    localparam int RANDOM_BEATS = 1250;
    localparam int STALL_LIMIT  = 4 * edh_pkg::LATENCY + 1000;
    localparam int CW           = edh_pkg::CW;

    logic clk, rst_n, start, busy, done;
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
    logic [edh_pkg::RW-1:0] dist_res;
    int errors;
    int quiet_cycles = 0;

    euclidean_distance_3d_heron DUT (.*);

    edh_checker u_checker (.*);

    initial clk = 0;
    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    function automatic logic signed [CW-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(CW-1){1'b0}}};
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return '0;
            3: return CW'($urandom_range(0, 16383)) - CW'(8192);
            4: return CW'($urandom_range(0, 255)) - CW'(128);
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic send_beat(logic signed [CW-1:0] pax, pay, paz, pbx, pby, pbz);
        ax <= pax; ay <= pay; az <= paz;
        bx <= pbx; by <= pby; bz <= pbz;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_gap(bit allow);
        if (allow && $urandom_range(0, 99) < 22)
        begin
            start <= 1'b0;
            ax <= CW'($urandom);
            @(posedge clk);
        end
    endtask

    initial
    begin
        logic signed [CW-1:0] lo, hi, zr;
        lo = {1'b1, {(CW-1){1'b0}}};
        hi = {1'b0, {(CW-1){1'b1}}};
        zr = '0;
        rst_n = 0;
        start = 0;
        {ax, ay, az, bx, by, bz} = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(zr, zr, zr, zr, zr, zr);
        send_beat(hi, hi, hi, lo, lo, lo);
        send_beat(lo, lo, lo, hi, hi, hi);
        send_beat(lo, lo, lo, zr, zr, zr);
        send_beat(hi, zr, zr, zr, zr, zr);
        send_beat(zr, lo, zr, zr, zr, zr);
        send_beat(24'sd1, zr, zr, zr, zr, zr);
        send_beat(24'sd90, zr, zr, zr, zr, zr);
        send_beat(24'sd91, zr, zr, zr, zr, zr);
        send_beat(24'sd4096, 24'sd4096, 24'sd4096, zr, zr, zr);
        send_beat(24'sd4096, zr, zr, -24'sd4096, zr, zr);
        send_beat(-24'sd1, -24'sd1, -24'sd1, 24'sd1, 24'sd1, 24'sd1);
        send_beat(hi, hi, hi, hi, hi, hi);
        send_beat(24'sd12288, 24'sd16384, zr, zr, zr, zr);
        send_beat(-24'sd5, 24'sd7, 24'sd3, 24'sd2, -24'sd9, 24'sd1);

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            idle_gap(i < 400 || i >= 700);
            if ($urandom_range(0, 4) == 0)
                send_beat(pick_coord(), pick_coord(), pick_coord(), zr, zr, zr);
            else
                send_beat(pick_coord(), pick_coord(), pick_coord(),
                          pick_coord(), pick_coord(), pick_coord());
        end
        start <= 1'b0;
        while (u_checker.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_euclidean_distance_3d_heron: PASS");
        else
            $display("tb_euclidean_distance_3d_heron: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("tb_euclidean_distance_3d_heron: FAIL");
            $finish;
        end
    end

endmodule
